// ===== design/lcdnw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdnw_pkg: shared types and constants for the character LCD number writer
// Request op codes, the microcode word layout, the microprogram and the
// control word that runs the binary-to-BCD converter.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

  // Field widths
  localparam int ValueW  = 16;
  localparam int ByteW   = 8;
  localparam int OpW     = 3;
  localparam int LineW   = 2;
  localparam int ColumnW = 6;
  localparam int DcountW = 5;

  // Digit limit and the counters that follow from it
  localparam int MaxDigits = 16;
  localparam int CntW      = $clog2(MaxDigits + 1);
  localparam int IdxW      = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;

  // Decimal conversion: 5 BCD digits cover 0..65535
  localparam int BcdDigits = 5;
  localparam int BcdW      = 4 * BcdDigits;
  localparam int BitCntW   = $clog2(ValueW);
  localparam int HexDigits = ValueW / 4;

  // Request op codes
  localparam logic [OpW-1:0] OpInit = 3'd0;
  localparam logic [OpW-1:0] OpChar = 3'd1;
  localparam logic [OpW-1:0] OpUdec = 3'd2;
  localparam logic [OpW-1:0] OpSdec = 3'd3;
  localparam logic [OpW-1:0] OpHex  = 3'd4;
  localparam logic [OpW-1:0] OpBin  = 3'd5;

  // Display lines that take a cursor command
  localparam logic [LineW-1:0] LineOne = 2'd1;
  localparam logic [LineW-1:0] LineTwo = 2'd2;

  // LCD bytes
  localparam logic [ByteW-1:0] CmdFuncSet  = 8'h38;
  localparam logic [ByteW-1:0] CmdDispOn   = 8'h0C;
  localparam logic [ByteW-1:0] CmdEntry    = 8'h06;
  localparam logic [ByteW-1:0] CmdClear    = 8'h01;
  localparam logic [ByteW-1:0] CmdSetDdram = 8'h80;
  localparam logic [ByteW-1:0] Line2Offset = 8'h40;
  localparam logic [ByteW-1:0] ChMinus     = 8'h2D;
  localparam logic [ByteW-1:0] ChPlus      = 8'h2B;
  localparam logic [ByteW-1:0] ChZero      = 8'h30;
  localparam logic [ByteW-1:0] ChAlphaBase = 8'h37;  // 'A' - 10

  // Microprogram addresses
  localparam int PcW = 4;
  localparam logic [PcW-1:0] PcIdle  = 4'd0;
  localparam logic [PcW-1:0] PcInit  = 4'd1;
  localparam logic [PcW-1:0] PcDisp  = 4'd5;
  localparam logic [PcW-1:0] PcConv  = 4'd6;
  localparam logic [PcW-1:0] PcDigit = 4'd10;

  // Datapath action of one step
  typedef enum logic [2:0] {
    ActNone   = 3'd0,
    ActConst  = 3'd1,
    ActCursor = 3'd2,
    ActSign   = 3'd3,
    ActChar   = 3'd4,
    ActDigit  = 3'd5,
    ActConv   = 3'd6
  } act_e;

  // Jump condition; when false the step counter advances by one
  typedef enum logic [2:0] {
    CondNext     = 3'd0,
    CondAlways   = 3'd1,
    CondNotDec   = 3'd2,
    CondConvMore = 3'd3,
    CondIsChar   = 3'd4,
    CondDigMore  = 3'd5
  } cond_e;

  typedef struct packed {
    act_e             act;
    cond_e            cond;
    logic [PcW-1:0]   tgt;
    logic [ByteW-1:0] data;
    logic             last;
  } uword_t;

  // Converter control
  typedef struct packed {
    logic load;
    logic step;
  } bcd_ctrl_t;

  // Microprogram ROM
  function automatic uword_t ucode_rd(logic [PcW-1:0] pc);
    uword_t w;
    w = '{act: ActNone, cond: CondAlways, tgt: PcIdle, data: '0, last: 1'b0};
    case (pc)
      // init: four fixed commands
      4'd1: w = '{act: ActConst, cond: CondNext, tgt: PcIdle, data: CmdFuncSet,
                  last: 1'b0};
      4'd2: w = '{act: ActConst, cond: CondNext, tgt: PcIdle, data: CmdDispOn,
                  last: 1'b0};
      4'd3: w = '{act: ActConst, cond: CondNext, tgt: PcIdle, data: CmdEntry,
                  last: 1'b0};
      4'd4: w = '{act: ActConst, cond: CondAlways, tgt: PcIdle, data: CmdClear,
                  last: 1'b1};
      // display: skip conversion unless decimal
      4'd5: w = '{act: ActNone, cond: CondNotDec, tgt: 4'd7, data: '0, last: 1'b0};
      4'd6: w = '{act: ActConv, cond: CondConvMore, tgt: PcConv, data: '0,
                  last: 1'b0};
      4'd7: w = '{act: ActCursor, cond: CondNext, tgt: PcIdle, data: '0, last: 1'b0};
      4'd8: w = '{act: ActSign, cond: CondNext, tgt: PcIdle, data: '0, last: 1'b0};
      4'd9: w = '{act: ActChar, cond: CondIsChar, tgt: PcIdle, data: '0, last: 1'b1};
      4'd10: w = '{act: ActDigit, cond: CondDigMore, tgt: PcDigit, data: '0,
                   last: 1'b0};
      4'd11: w = '{act: ActNone, cond: CondAlways, tgt: PcIdle, data: '0, last: 1'b0};
      default: w = '{act: ActNone, cond: CondAlways, tgt: PcIdle, data: '0,
                     last: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ===== design/char_lcd_number_writer_top.sv =====
// ----------------------------------------------------------------------------
// char_lcd_number_writer_top: character LCD number writer
// Turns each request into a run of LCD bus writes under microcode control.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one request word: op,
//   line, column, value and digit_count. in_stall_o is high while a request
//   is being worked off; unknown op codes are taken and dropped.
//   Output channel (out_valid_o / out_stall_i) gives one bus write per word:
//   reg_select, bus_byte and last, which marks the final write of a request.
//   A microprogram steps through the request one control word per cycle,
//   except while a step that writes waits for the output register. Init
//   gives 4 writes. Display requests take a dispatch step, then for decimal
//   ops a conversion step per value bit (one bit per cycle through the BCD
//   converter), then a step each for cursor, sign, char and each digit,
//   plus one return step. The first write follows the dispatch step (and
//   the conversion for decimal) and is held in the output register.
//   When the receiver stalls, the output register holds its word and the
//   sequencer waits on the step that wants to write; nothing is lost.
//   Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module char_lcd_number_writer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lcdnw_pkg::OpW-1:0]           op_i,
  input  logic [lcdnw_pkg::LineW-1:0]         line_i,
  input  logic [lcdnw_pkg::ColumnW-1:0]       column_i,
  input  logic signed [lcdnw_pkg::ValueW-1:0] value_i,
  input  logic [lcdnw_pkg::DcountW-1:0]       digit_count_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                reg_select_o,
  output logic [lcdnw_pkg::ByteW-1:0]         bus_byte_o,
  output logic                                last_o
);
  import lcdnw_pkg::*;

  // request registers
  logic [PcW-1:0]     pc_q, pc_d;
  logic [OpW-1:0]     op_q;
  logic [LineW-1:0]   line_q;
  logic [ColumnW-1:0] column_q;
  logic [ValueW-1:0]  value_q;
  logic [CntW-1:0]    cnt_q, cnt_d;

  // output register
  logic             ovalid_q, ovalid_d;
  logic             rs_q, rs_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             last_q, last_d;

  logic             accept, out_free, fire, emit, jump;
  logic             e_rs, e_last;
  logic [ByteW-1:0] e_byte, pos;
  logic             neg, is_dec;
  logic [ValueW-1:0] mag;
  logic [IdxW-1:0]  k;
  logic [3:0]       dig;
  logic [3:0]       bcd_dig [BcdDigits];
  logic [BcdW-1:0]  bcd;
  logic             conv_more;
  bcd_ctrl_t        bcd_ctrl;
  uword_t           w;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (pc_q != PcIdle);
  assign out_free = !ovalid_q || !out_stall_i;
  assign w        = ucode_rd(pc_q);

  // signed magnitude; -32768 keeps its pattern 0x8000
  assign neg = value_i[ValueW-1];
  assign mag = neg ? (~value_i + 1'b1) : value_i;
  assign is_dec = (op_q == OpUdec) || (op_q == OpSdec);

  // decimal converter
  assign bcd_ctrl.load = accept;
  assign bcd_ctrl.step = (w.act == ActConv);

  lcdnw_bcd u_bcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (bcd_ctrl),
    .value_i((op_i == OpSdec) ? mag : value_i),
    .bcd_o  (bcd),
    .more_o (conv_more)
  );

  // digit at position cnt-1, zero past the value's range
  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      bcd_dig[i] = bcd[4*i +: 4];
    end
    k   = IdxW'(cnt_q - 1'b1);
    dig = '0;
    if (is_dec) begin
      if (int'(k) < BcdDigits) begin
        dig = bcd_dig[k[2:0]];
      end
    end else if (op_q == OpHex) begin
      if (int'(k) < HexDigits) begin
        dig = value_q[{k[1:0], 2'b00} +: 4];
      end
    end else begin
      if (int'(k) < ValueW) begin
        dig = {3'b000, value_q[k[3:0]]};
      end
    end
  end

  // cursor position, modulo 256
  assign pos = ByteW'(column_q) - 8'd1 + ((line_q == LineTwo) ? Line2Offset : 8'd0);

  // datapath action of the current step
  always_comb begin
    emit   = 1'b0;
    e_rs   = 1'b1;
    e_byte = '0;
    e_last = 1'b0;
    case (w.act)
      ActConst: begin
        emit   = 1'b1;
        e_rs   = 1'b0;
        e_byte = w.data;
        e_last = w.last;
      end
      ActCursor: begin
        emit   = (line_q == LineOne) || (line_q == LineTwo);
        e_rs   = 1'b0;
        e_byte = CmdSetDdram | pos;
        e_last = (op_q != OpChar) && (op_q != OpSdec) && (cnt_q == '0);
      end
      ActSign: begin
        emit   = (op_q == OpSdec);
        e_byte = value_q[ValueW-1] ? ChMinus : ChPlus;
        e_last = (cnt_q == '0);
      end
      ActChar: begin
        emit   = (op_q == OpChar);
        e_byte = value_q[ByteW-1:0];
        e_last = w.last;
      end
      ActDigit: begin
        emit   = (cnt_q != '0);
        e_byte = (dig < 4'd10) ? (ChZero + ByteW'(dig)) : (ChAlphaBase + ByteW'(dig));
        e_last = (cnt_q == CntW'(1));
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // jump condition
  always_comb begin
    case (w.cond)
      CondNext:     jump = 1'b0;
      CondAlways:   jump = 1'b1;
      CondNotDec:   jump = !is_dec;
      CondConvMore: jump = conv_more;
      CondIsChar:   jump = (op_q == OpChar);
      CondDigMore:  jump = (cnt_q > CntW'(1));
      default:      jump = 1'b1;
    endcase
  end

  // a step that writes waits for room in the output register
  assign fire = (pc_q != PcIdle) && (!emit || out_free);

  // sequencer
  always_comb begin
    pc_d  = pc_q;
    cnt_d = cnt_q;
    if (pc_q == PcIdle) begin
      if (accept) begin
        if (op_i == OpInit) begin
          pc_d = PcInit;
        end else if (op_i == OpChar || op_i == OpUdec || op_i == OpSdec ||
                     op_i == OpHex || op_i == OpBin) begin
          pc_d = PcDisp;
        end
        if (int'(digit_count_i) > MaxDigits) begin
          cnt_d = CntW'(MaxDigits);
        end else begin
          cnt_d = CntW'(digit_count_i);
        end
      end
    end else if (fire) begin
      pc_d = jump ? w.tgt : pc_q + 1'b1;
      if (w.act == ActDigit && emit) begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // output register
  always_comb begin
    ovalid_d = ovalid_q;
    rs_d     = rs_q;
    byte_d   = byte_q;
    last_d   = last_q;
    if (fire && emit) begin
      ovalid_d = 1'b1;
      rs_d     = e_rs;
      byte_d   = e_byte;
      last_d   = e_last;
    end else if (!out_stall_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= PcIdle;
      ovalid_q <= 1'b0;
    end else begin
      pc_q     <= pc_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    rs_q   <= rs_d;
    byte_q <= byte_d;
    last_q <= last_d;
    if (accept) begin
      op_q     <= op_i;
      line_q   <= line_i;
      column_q <= column_i;
      value_q  <= value_i;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign reg_select_o = rs_q;
  assign bus_byte_o   = byte_q;
  assign last_o       = last_q;

endmodule

// ===== design/lcdnw_bcd.sv =====
// ----------------------------------------------------------------------------
// lcdnw_bcd: serial binary to BCD converter
// Shift-and-add-3, one input bit per step; sixteen steps after a load.
// ----------------------------------------------------------------------------
module lcdnw_bcd (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  lcdnw_pkg::bcd_ctrl_t                   ctrl_i,
  input  logic [lcdnw_pkg::ValueW-1:0]           value_i,
  output logic [lcdnw_pkg::BcdW-1:0]             bcd_o,
  output logic                                   more_o
);
  import lcdnw_pkg::*;

  logic [ValueW-1:0]  bin_q, bin_d;
  logic [BcdW-1:0]    bcd_q, bcd_d;
  logic [BitCntW-1:0] bit_q, bit_d;
  logic [BcdW-1:0]    adj;

  // add 3 to every digit of 5 or more, then shift one bit in
  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                               : bcd_q[4*i +: 4];
    end
    bin_d = bin_q;
    bcd_d = bcd_q;
    bit_d = bit_q;
    if (ctrl_i.load) begin
      bin_d = value_i;
      bcd_d = '0;
      bit_d = '0;
    end else if (ctrl_i.step) begin
      bcd_d = {adj[BcdW-2:0], bin_q[ValueW-1]};
      bin_d = {bin_q[ValueW-2:0], 1'b0};
      bit_d = bit_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else begin
      bit_q <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign bcd_o  = bcd_q;
  assign more_o = (bit_q != BitCntW'(ValueW - 1));

endmodule
